// ===== rtl/core/jst_pkg.sv =====
// shared types, codes and constants of the job slot table
package jst_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam int KEY_W          = 31;
    localparam int ST_W           = 2;
    localparam int LIM_W          = 5;
    localparam int KIND_W         = 4;
    localparam int RC_W           = 2;
    localparam int IN_W           = 72;
    localparam int ENTRY_W        = KEY_W + KEY_W + ST_W;

    localparam logic [LIM_W-1:0] LIST_MAX = 5'd16;
    localparam logic [KEY_W-1:0] ID_MAX   = 31'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] ID_FIRST = 31'd1;

    localparam logic [ST_W-1:0] ST_DONE = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ADD      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_FIND_ID  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_FIND_GRP = 4'd3;
    localparam logic [KIND_W-1:0] KIND_SET_ID   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SET_GRP  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_LIST     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SWEEP    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 4'd8;

    localparam logic [RC_W-1:0] RC_OK        = 2'd0;
    localparam logic [RC_W-1:0] RC_FULL      = 2'd1;
    localparam logic [RC_W-1:0] RC_NOT_FOUND = 2'd2;
    localparam logic [RC_W-1:0] RC_EMPTY     = 2'd3;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_REMOVE,
        OP_FIND_ID,
        OP_FIND_GRP,
        OP_SET_ID,
        OP_SET_GRP,
        OP_LIST,
        OP_SWEEP,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_RD,
        B_CHK,
        B_EMIT
    } bstate_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] job_key;
        logic [KEY_W-1:0] group_key;
        logic [ST_W-1:0]  state;
        logic [LIM_W-1:0] limit;
    } cmd_t;

    typedef struct packed {
        logic [RC_W-1:0]  code;
        logic [KEY_W-1:0] job_id;
        logic [KEY_W-1:0] group;
        logic [ST_W-1:0]  state;
        logic             last;
    } res_t;

    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

endpackage

// ===== rtl/core/jst_ram.sv =====
// generic single-port-write ram with registered read
module jst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/jst_front.sv =====
// front end: unpacks an input word and classifies it into a command
module jst_front import jst_pkg::*; (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [KIND_W-1:0] s_tuser,
    input  qstat_t            q_stat,
    output logic              push,
    output cmd_t              cmd
);
    logic [ST_W-1:0]  st_raw;
    logic [LIM_W-1:0] lim_raw;

    assign st_raw  = s_tdata[63:62];
    assign lim_raw = s_tdata[68:64];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    always_comb begin
        cmd.job_key   = s_tdata[30:0];
        cmd.group_key = s_tdata[61:31];
        // state three is kept as done
        cmd.state     = (st_raw == ST_BAD) ? ST_DONE : st_raw;
        cmd.limit     = (lim_raw > LIST_MAX) ? LIST_MAX : lim_raw;
        case (s_tuser)
            KIND_ADD:      cmd.op = OP_ADD;
            KIND_REMOVE:   cmd.op = OP_REMOVE;
            KIND_FIND_ID:  cmd.op = OP_FIND_ID;
            KIND_FIND_GRP: cmd.op = OP_FIND_GRP;
            KIND_SET_ID:   cmd.op = OP_SET_ID;
            KIND_SET_GRP:  cmd.op = OP_SET_GRP;
            KIND_LIST:     cmd.op = OP_LIST;
            KIND_SWEEP:    cmd.op = OP_SWEEP;
            KIND_CLEAR:    cmd.op = OP_CLEAR;
            default:       cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/jst_cmd_queue.sv =====
// two-entry command queue between front and back
module jst_cmd_queue import jst_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  cmd_t   push_cmd,
    input  logic   pop,
    output qstat_t stat,
    output cmd_t   head
);
    cmd_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign stat.valid = (cnt_reg != 2'd0);
    assign stat.full  = (cnt_reg == 2'd2);
    assign head       = q_mem[rd_ptr_reg];
    assign do_pop     = pop && stat.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/jst_back.sv =====
// back end: slot sequencer that walks the table and drives the result register
module jst_back import jst_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1,
    localparam int CW = $clog2(TABLE_SIZE + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  qstat_t               q_stat,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output res_t                 out_res,
    output logic [CW-1:0]        out_count,
    output logic [KEY_W-1:0]     out_next_id
);
    bstate_t           state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [TABLE_SIZE-1:0] valid_reg, valid_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [KEY_W-1:0]  ctr_reg, ctr_next;
    res_t              res_reg, res_next;
    logic              pend_reg, pend_next;
    logic [LIM_W-1:0]  nlist_reg, nlist_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg, out_res_next;
    logic [CW-1:0]     out_cnt_reg, out_cnt_next;
    logic [KEY_W-1:0]  out_nid_reg, out_nid_next;

    logic              ram_we;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [KEY_W-1:0]  e_id, e_grp;
    logic [ST_W-1:0]   e_st;
    logic              e_valid, last_idx, out_free, hit, qual, list_end;
    res_t              entry;

    jst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign e_id     = ram_rdata[30:0];
    assign e_grp    = ram_rdata[61:31];
    assign e_st     = ram_rdata[63:62];
    assign e_valid  = valid_reg[idx_reg];
    assign last_idx = (idx_reg == IW'(TABLE_SIZE - 1));
    assign out_free = !out_valid_reg || out_ready;
    assign qual     = e_valid && (e_st != ST_DONE);

    always_comb begin
        entry = '{code: RC_OK, job_id: e_id, group: e_grp, state: e_st, last: 1'b1};
        case (cmd_reg.op)
            OP_FIND_GRP, OP_SET_GRP: hit = e_valid && (e_grp == cmd_reg.group_key);
            default: hit = e_valid && (cmd_reg.job_key != '0) && (e_id == cmd_reg.job_key);
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        ctr_next       = ctr_reg;
        res_next       = res_reg;
        pend_next      = pend_reg;
        nlist_next     = nlist_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        out_cnt_next   = out_cnt_reg;
        out_nid_next   = out_nid_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = '0;
        list_end       = 1'b0;

        case (state_reg)
            B_IDLE: begin
                if (q_stat.valid) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    nlist_next = '0;
                    res_next   = '{code: RC_OK, job_id: '0, group: '0, state: '0, last: 1'b1};
                    case (q_cmd.op)
                        OP_ADD: begin
                            if (count_reg == CW'(TABLE_SIZE) || ctr_reg == ID_MAX) begin
                                res_next.code = RC_FULL;
                                state_next    = B_EMIT;
                            end else begin
                                state_next = B_SCAN;
                            end
                        end
                        OP_LIST: begin
                            if (q_cmd.limit == '0) begin
                                res_next.code = RC_EMPTY;
                                state_next    = B_EMIT;
                            end else begin
                                state_next = B_RD;
                            end
                        end
                        OP_CLEAR: begin
                            valid_next = '0;
                            count_next = '0;
                            ctr_next   = ID_FIRST;
                            state_next = B_EMIT;
                        end
                        OP_NOP: begin
                            state_next = B_EMIT;
                        end
                        default: begin
                            state_next = B_RD;
                        end
                    endcase
                end
            end
            B_SCAN: begin
                // a free slot is known to exist here
                if (!e_valid) begin
                    ram_we              = 1'b1;
                    ram_wdata           = {cmd_reg.state, cmd_reg.group_key, ctr_reg};
                    valid_next[idx_reg] = 1'b1;
                    count_next          = count_reg + CW'(1);
                    ctr_next            = ctr_reg + KEY_W'(1);
                    res_next            = '{code: RC_OK, job_id: ctr_reg,
                                            group: cmd_reg.group_key,
                                            state: cmd_reg.state, last: 1'b1};
                    state_next          = B_EMIT;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            B_RD: begin
                state_next = B_CHK;
            end
            B_CHK: begin
                case (cmd_reg.op)
                    OP_SWEEP: begin
                        if (e_valid && e_st == ST_DONE) begin
                            valid_next[idx_reg] = 1'b0;
                            count_next          = count_reg - CW'(1);
                        end
                        if (last_idx) begin
                            state_next = B_EMIT;
                        end else begin
                            idx_next   = idx_reg + IW'(1);
                            state_next = B_RD;
                        end
                    end
                    OP_LIST: begin
                        // hold one entry back so the final one can carry last
                        if (!(qual && pend_reg && !out_free)) begin
                            if (qual) begin
                                if (pend_reg) begin
                                    out_valid_next    = 1'b1;
                                    out_res_next      = res_reg;
                                    out_res_next.last = 1'b0;
                                    out_cnt_next      = count_reg;
                                    out_nid_next      = ctr_reg;
                                end
                                res_next   = entry;
                                pend_next  = 1'b1;
                                nlist_next = nlist_reg + LIM_W'(1);
                            end
                            list_end = (qual && (nlist_reg + LIM_W'(1) == cmd_reg.limit))
                                       || last_idx;
                            if (list_end) begin
                                if (!(qual || pend_reg)) begin
                                    res_next.code = RC_EMPTY;
                                end
                                state_next = B_EMIT;
                            end else begin
                                idx_next   = idx_reg + IW'(1);
                                state_next = B_RD;
                            end
                        end
                    end
                    OP_REMOVE, OP_FIND_ID, OP_FIND_GRP, OP_SET_ID, OP_SET_GRP: begin
                        if (hit) begin
                            res_next = entry;
                            case (cmd_reg.op)
                                OP_REMOVE: begin
                                    valid_next[idx_reg] = 1'b0;
                                    count_next          = count_reg - CW'(1);
                                end
                                OP_SET_ID, OP_SET_GRP: begin
                                    ram_we         = 1'b1;
                                    ram_wdata      = {cmd_reg.state, e_grp, e_id};
                                    res_next.state = cmd_reg.state;
                                end
                                default: begin
                                end
                            endcase
                            state_next = B_EMIT;
                        end else if (last_idx) begin
                            res_next.code = RC_NOT_FOUND;
                            state_next    = B_EMIT;
                        end else begin
                            idx_next   = idx_reg + IW'(1);
                            state_next = B_RD;
                        end
                    end
                    default: begin
                        state_next = B_EMIT;
                    end
                endcase
            end
            B_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_cnt_next   = count_reg;
                    out_nid_next   = ctr_reg;
                    state_next     = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            ctr_reg       <= ID_FIRST;
            pend_reg      <= 1'b0;
            nlist_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            ctr_reg       <= ctr_next;
            pend_reg      <= pend_next;
            nlist_reg     <= nlist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
        out_cnt_reg <= out_cnt_next;
        out_nid_reg <= out_nid_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_res     = out_res_reg;
    assign out_count   = out_cnt_reg;
    assign out_next_id = out_nid_reg;

endmodule

// ===== rtl/core/job_slot_table.sv =====
// top level of the job slot table: front decode, command queue, slot sequencer
//
//  channel  dir  handshake          tdata                               tuser        tlast
//  s_       in   s_tvalid/s_tready  key, group, state, limit (72 bits)  kind         -
//  m_       out  m_tvalid/m_tready  id, group, state, count, next id    result code  last result
//
//  add: steps past each occupied slot ahead of the first free one
//  remove, find, set state, sweep, list: a read state and a check state per slot visited, since
//  the sequencer reads one slot ram entry per visit through its registered port
//  clear and unknown kinds walk no slots; list words leave one entry behind as they are found
//  reset clears valid bits and live count and sets the id counter to its first id at once, no ram sweep
//  two commands may wait in the queue while the sequencer or result stalls
module job_slot_table import jst_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int CW       = $clog2(TABLE_SIZE + 1),
    localparam int OUT_BITS = KEY_W + KEY_W + ST_W + CW + KEY_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // job_key[30:0], group_key[61:31], new_state[63:62], list_limit[68:64]
    input  logic [IN_W-1:0]     s_tdata,
    // kind[3:0]
    input  logic [KIND_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_job_id[30:0], out_group[61:31], out_state[63:62],
    // live_count[64 +: CW], next_id above it
    output logic [OUT_W-1:0]    m_tdata,
    // result_code[1:0]
    output logic [RC_W-1:0]     m_tuser,
    output logic                m_tlast
);
    qstat_t           q_stat;
    cmd_t             front_cmd, q_head;
    logic             q_push, q_pop;
    res_t             res;
    logic [CW-1:0]    res_count;
    logic [KEY_W-1:0] res_next_id;

    // front: unpack and classify each input word
    jst_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (q_push),
        .cmd      (front_cmd)
    );

    // queue lets the front keep taking words while the back walks the table
    jst_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .stat     (q_stat),
        .head     (q_head)
    );

    // back: slot table state and the result register
    jst_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_stat      (q_stat),
        .q_cmd       (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res),
        .out_count   (res_count),
        .out_next_id (res_next_id)
    );

    // pack result fields, low field first, zero fill to whole bytes
    assign m_tdata = OUT_W'({res_next_id, res_count, res.state, res.group, res.job_id});
    assign m_tuser = res.code;
    assign m_tlast = res.last;

    // a word that names no entry is always the only word of its command
    a_blank_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == RC_FULL || m_tuser == RC_NOT_FOUND || m_tuser == RC_EMPTY)
        |-> m_tlast && (m_tdata[30:0] == '0))
        else $error("failed or empty result not final or names an entry");

    // live count never goes past the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[64 +: CW] <= CW'(TABLE_SIZE)))
        else $error("live count beyond table size");

    // next id is never zero
    a_next_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[64 + CW +: KEY_W] != '0))
        else $error("next id is zero");

    // an ok result that names an entry never reports the id counter limit
    a_add_id_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == RC_OK) && (m_tdata[30:0] != '0)
        && (m_tdata[63:62] != ST_BAD) |-> (m_tdata[30:0] != ID_MAX))
        else $error("reported id at counter limit");

endmodule
